// ----- hw/rtl/sorted_priority_queue_defines.svh -----
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Concurrent assertion wrappers, used by the queue's datapath.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Checked on every rising edge outside of reset.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, during reset as well.
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- hw/rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Request and response types, status and opcode codes, and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OccW = 5;

  // Opcodes of a request.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  // Status codes of a response.
  localparam logic [StatusW-1:0] STATUS_DONE  = 2'd0;
  localparam logic [StatusW-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [StatusW-1:0] STATUS_FULL  = 2'd2;

  // One request.
  typedef struct packed {
    logic                     opcode;
    logic signed [ValueW-1:0] value;
  } req_t;

  // One response.
  typedef struct packed {
    logic signed [ValueW-1:0] popped_value;
    logic [StatusW-1:0]       status;
    logic [OccW-1:0]          occupancy;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic               load;
    logic               do_insert;
    logic               do_pop;
    logic               emit;
    logic [StatusW-1:0] status;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_pop;
    logic empty;
    logic full;
  } dp_status_t;

endpackage

// ----- hw/rtl/spq_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue controller
// Accepts a request, then decides in the execute cycle whether the datapath
// inserts, pops or only reports a failed request.
// ----------------------------------------------------------------------------
module spq_ctrl import spq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  dp_status_t dp_status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q;
  logic state_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.emit = 1'b1;
        if (dp_status_i.op_pop) begin
          if (dp_status_i.empty) begin
            cmd_o.status = STATUS_EMPTY;
          end else begin
            cmd_o.do_pop = 1'b1;
            cmd_o.status = STATUS_DONE;
          end
        end else begin
          if (dp_status_i.full) begin
            cmd_o.status = STATUS_FULL;
          end else begin
            cmd_o.do_insert = 1'b1;
            cmd_o.status    = STATUS_DONE;
          end
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

// ----- hw/rtl/spq_datapath.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue datapath
// A row of value cells kept in ascending order. Every cell compares itself
// with the request value, so an insert or a pop shifts the whole row at once.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_defines.svh"

module spq_datapath import spq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  req_t       req_i,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t dp_status_o,
  output logic       done_o,
  output rsp_t       rsp_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  req_t                     req_q;
  logic signed [ValueW-1:0] entries_q [DEPTH];
  logic signed [ValueW-1:0] entries_d [DEPTH];
  logic [DEPTH-1:0]         gt;
  logic [CntW-1:0]          count_q;
  logic [CntW-1:0]          count_d;
  logic [CntW+OccW-1:0]     occ_wide;
  logic                     done_q;
  rsp_t                     rsp_q;

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
  end

  assign dp_status_o.op_pop = (req_q.opcode == OP_POP);
  assign dp_status_o.empty  = (count_q == '0);
  assign dp_status_o.full   = (count_q == CntW'(DEPTH));

  // Cells. A cell is marked when it is empty or holds a value greater than
  // the request value; the first marked cell is the insert slot.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     prev_gt;
    logic signed [ValueW-1:0] prev_entry;
    logic signed [ValueW-1:0] next_entry;

    assign gt[i] = (CntW'(i) >= count_q) || (req_q.value < entries_q[i]);

    if (i == 0) begin : g_head
      assign prev_gt    = 1'b0;
      assign prev_entry = req_q.value;
    end else begin : g_body
      assign prev_gt    = gt[i-1];
      assign prev_entry = entries_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_entry = entries_q[i];
    end else begin : g_inner
      assign next_entry = entries_q[i+1];
    end

    always_comb begin
      entries_d[i] = entries_q[i];
      if (cmd_i.do_insert && gt[i]) begin
        entries_d[i] = prev_gt ? prev_entry : req_q.value;
      end else if (cmd_i.do_pop) begin
        entries_d[i] = next_entry;
      end
    end

    always_ff @(posedge clk_i) begin
      entries_q[i] <= entries_d[i];
    end
  end

  // Occupancy count.
  always_comb begin
    count_d = count_q;
    if (cmd_i.do_insert) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.do_pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign occ_wide = {{OccW{1'b0}}, count_d};

  // Response register and strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      rsp_q.popped_value <= cmd_i.do_pop ? entries_q[0] : '0;
      rsp_q.status       <= cmd_i.status;
      rsp_q.occupancy    <= occ_wide[OccW-1:0];
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // Assertions.
  `SPQ_ASSERT(a_count_bound, count_q <= CntW'(DEPTH), "occupancy above capacity")
  `SPQ_ASSERT(a_one_update, !(cmd_i.do_insert && cmd_i.do_pop), "insert and pop together")
  `SPQ_ASSERT(a_pop_count, cmd_i.do_pop |=> count_q == $past(count_q) - CntW'(1), "pop count")
  `SPQ_ASSERT_ALWAYS(a_strobe_reset, !rst_ni |=> !done_o, "response strobe during reset")

endmodule

// ----- hw/rtl/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded queue of signed values kept in ascending order. An insert goes
// behind every equal value; a pop returns the smallest value.
// ----------------------------------------------------------------------------
//   Channel    Handshake           Payload
//   request    start / busy        req_i  (opcode, value)
//   response   done_o strobe       rsp_o  (popped_value, status, occupancy)
//
// The accept edge captures a request; leaving the execute state updates the
// cell row and registers the response, and done_o is high for the cycle after
// that. busy is high only in the update cycle, so a new request may be accepted
// while the response strobe is shown, but not before the last one is executed.
// Reset clears the occupancy; stored values are not cleared and are never read
// before they are written. The response cannot be stalled.
// ----------------------------------------------------------------------------
module sorted_priority_queue import spq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .dp_status_i (dp_status),
    .cmd_o       (cmd)
  );

  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .dp_status_o (dp_status),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

endmodule
